// ===== sv/tlm_pkg.sv =====
`default_nettype none
package tlm_pkg;

  localparam int unsigned MaxToken = 24;
  localparam int unsigned LenW = 5;
  localparam int unsigned CfgW = 64;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned TokenBits = MaxToken * 8;

  localparam logic [CfgIdxW-1:0] REG_TOKEN_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TOKEN_WORD_0 = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TOKEN_WORD_1 = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TOKEN_WORD_2 = 2'd3;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] CHAR_END     = 8'h00;

  localparam logic [LenW-1:0] MAX_LEN     = LenW'(MaxToken);
  localparam logic [LenW-1:0] SAT_LEN     = LenW'(MaxToken + 1);

  typedef struct packed {
    logic [LenW-1:0]      length;
    logic [TokenBits-1:0] chars;
  } token_cfg_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB);
  endfunction

endpackage
`default_nettype wire

// ===== sv/tlm_config.sv =====
`default_nettype none
module tlm_config (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [tlm_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [tlm_pkg::CfgW-1:0]     cfg_data,
  output tlm_pkg::token_cfg_t               token
);

  logic [tlm_pkg::LenW-1:0] token_length;
  logic [tlm_pkg::CfgW-1:0] token_word_0;
  logic [tlm_pkg::CfgW-1:0] token_word_1;
  logic [tlm_pkg::CfgW-1:0] token_word_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_length <= '0;
      token_word_0 <= '0;
      token_word_1 <= '0;
      token_word_2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tlm_pkg::REG_TOKEN_LENGTH: token_length <= cfg_data[tlm_pkg::LenW-1:0];
        tlm_pkg::REG_TOKEN_WORD_0: token_word_0 <= cfg_data;
        tlm_pkg::REG_TOKEN_WORD_1: token_word_1 <= cfg_data;
        tlm_pkg::REG_TOKEN_WORD_2: token_word_2 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign token.length = token_length;
  assign token.chars  = {token_word_2, token_word_1, token_word_0};

endmodule
`default_nettype wire

// ===== sv/tlm_core.sv =====
`default_nettype none
module tlm_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tlm_pkg::token_cfg_t token,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_found
);

  logic                     inside_element;
  logic [tlm_pkg::LenW-1:0] element_position;
  logic [tlm_pkg::LenW-1:0] trimmed_length;
  logic                     element_mismatch;
  logic                     pending_space_mismatch;
  logic                     match_seen;

  logic                     inside_element_next;
  logic [tlm_pkg::LenW-1:0] element_position_next;
  logic [tlm_pkg::LenW-1:0] trimmed_length_next;
  logic                     element_mismatch_next;
  logic                     pending_space_mismatch_next;
  logic                     match_seen_next;

  logic                     accept;
  logic                     is_end;
  logic                     blank;
  logic                     comma;
  logic                     hits;
  logic                     starting;
  logic [tlm_pkg::LenW-1:0] p;
  logic                     mism_in;
  logic                     pend_in;
  logic [7:0]               tchar;
  logic                     same;
  logic                     found;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_end   = (in_byte == tlm_pkg::CHAR_END);
  assign blank    = tlm_pkg::is_blank(in_byte);
  assign comma    = (in_byte == tlm_pkg::CHAR_COMMA);

  assign hits = inside_element && !element_mismatch && (token.length != '0) &&
                (token.length <= tlm_pkg::MAX_LEN) && (trimmed_length == token.length);
  assign found = match_seen || hits;

  assign starting = !inside_element;
  assign p        = starting ? '0 : element_position;
  assign mism_in  = starting ? 1'b0 : element_mismatch;
  assign pend_in  = starting ? 1'b0 : pending_space_mismatch;

  always_comb begin
    tchar = '0;
    if (p < tlm_pkg::MAX_LEN) begin
      tchar = token.chars[p*8 +: 8];
    end
  end

  assign same = (p < token.length) && (p < tlm_pkg::MAX_LEN) &&
                (tlm_pkg::fold_case(in_byte) == tlm_pkg::fold_case(tchar));

  always_comb begin
    inside_element_next         = inside_element;
    element_position_next       = element_position;
    trimmed_length_next         = trimmed_length;
    element_mismatch_next       = element_mismatch;
    pending_space_mismatch_next = pending_space_mismatch;
    match_seen_next             = match_seen;
    if (is_end) begin
      inside_element_next         = 1'b0;
      element_position_next       = '0;
      trimmed_length_next         = '0;
      element_mismatch_next       = 1'b0;
      pending_space_mismatch_next = 1'b0;
      match_seen_next             = 1'b0;
    end else if (inside_element && comma) begin
      if (hits) begin
        match_seen_next = 1'b1;
      end
      inside_element_next = 1'b0;
    end else if (inside_element || (!blank && !comma)) begin
      inside_element_next         = 1'b1;
      trimmed_length_next         = starting ? '0 : trimmed_length;
      element_mismatch_next       = mism_in;
      pending_space_mismatch_next = pend_in;
      if (blank) begin
        if (!same) begin
          pending_space_mismatch_next = 1'b1;
        end
      end else begin
        if (pend_in || !same) begin
          element_mismatch_next = 1'b1;
        end
        pending_space_mismatch_next = 1'b0;
        trimmed_length_next = (p < tlm_pkg::SAT_LEN) ? p + 1'b1 : tlm_pkg::SAT_LEN;
      end
      element_position_next = (p < tlm_pkg::SAT_LEN) ? p + 1'b1 : p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_element         <= 1'b0;
      element_position       <= '0;
      trimmed_length         <= '0;
      element_mismatch       <= 1'b0;
      pending_space_mismatch <= 1'b0;
      match_seen             <= 1'b0;
    end else if (accept) begin
      inside_element         <= inside_element_next;
      element_position       <= element_position_next;
      trimmed_length         <= trimmed_length_next;
      element_mismatch       <= element_mismatch_next;
      pending_space_mismatch <= pending_space_mismatch_next;
      match_seen             <= match_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && is_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_end) begin
      out_found <= found;
    end
  end

endmodule
`default_nettype wire

// ===== sv/token_list_matcher_top.sv =====
// Token list matcher: checks whether a configured token is one element of
// a comma-separated header value list, ignoring ASCII case.
// Input channel s_*: one list byte per word in s_tdata; a zero byte ends
// the list. Output channel m_*: one word per list, token_found in bit 0.
// Config port: cfg_we, cfg_index (0 length, 1..3 token words), cfg_data;
// write only while no list is in flight.
// Throughput: one byte per cycle while s_tready is high, set by the state
// update between the element state registers and the result register.
// Result: m_tvalid rises in the cycle after the zero byte is accepted.
// Stall: s_tready is high while the result register is empty or being
// taken; while m_tready is low with a result held, s_tready drops.
// Reset (rst, synchronous): clears element state, the result valid flag and
// all configuration registers (token length zero, which never matches).
`default_nettype none
module token_list_matcher_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [7:0]                   s_tdata,   // [7:0] list_byte
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [7:0]                        m_tdata,   // [0] token_found, [7:1] zero
  input  wire logic                         cfg_we,
  input  wire logic [tlm_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [tlm_pkg::CfgW-1:0]     cfg_data
);

  tlm_pkg::token_cfg_t token;
  logic                found;

  tlm_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .token     (token)
  );

  tlm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .token     (token),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_found (found)
  );

  assign m_tdata = {7'b0, found};

endmodule
`default_nettype wire
